### design/shms_pkg.sv
package shms_pkg;

    localparam int CHAR_W  = 8;
    localparam int CODE_W  = 32;
    localparam int SLOT_W  = 31;
    localparam int CFG_W   = 32;
    localparam int IDX_W   = 2;
    localparam int STEP_W  = 5;

    localparam logic [CODE_W-1:0] MULT_RESET   = 32'd33;
    localparam logic [SLOT_W-1:0] FACTOR_RESET = 31'd1;
    localparam logic [SLOT_W-1:0] SHIFT_RESET  = 31'd0;
    localparam logic [SLOT_W-1:0] TSIZE_RESET  = 31'd101;

    localparam logic [STEP_W-1:0] STEP_LAST = 5'd31;

    typedef enum logic [IDX_W-1:0] {
        CFG_MULT   = 2'd0,
        CFG_FACTOR = 2'd1,
        CFG_SHIFT  = 2'd2,
        CFG_TSIZE  = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic code_step;
        logic mad_load;
        logic div_step;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic char_zero;
        logic out_free;
    } t_sts;

endpackage

### design/shms_ctrl.sv
module shms_ctrl
    import shms_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIV,
        S_FIN
    } t_state;

    t_state              r_state;
    logic [STEP_W-1:0]   r_step;
    logic                w_accept;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;

    always_comb begin
        o_cmd.code_step = w_accept && !i_sts.char_zero;
        o_cmd.mad_load  = w_accept && i_sts.char_zero;
        o_cmd.div_step  = (r_state == S_DIV);
        o_cmd.out_load  = (r_state == S_FIN) && i_sts.out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    r_step <= '0;
                    if (o_cmd.mad_load) begin
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    r_step <= r_step + 1'b1;
                    if (r_step == STEP_LAST) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    // hold until the output register can take the slot
                    if (i_sts.out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

### design/shms_dp.sv
module shms_dp
    import shms_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    input  logic [IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_W-1:0]  i_cfg_data,
    input  logic [CHAR_W-1:0] i_char,
    input  t_cmd              i_cmd,
    output t_sts              o_sts,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [SLOT_W-1:0] o_slot
);

    logic [CODE_W-1:0] r_mult;
    logic [SLOT_W-1:0] r_factor;
    logic [SLOT_W-1:0] r_shift;
    logic [SLOT_W-1:0] r_tsize;
    logic [CODE_W-1:0] r_code;
    logic [CODE_W-1:0] r_dvd;
    logic [SLOT_W-1:0] r_rem;
    logic [SLOT_W-1:0] r_out;
    logic              r_out_valid;

    logic [CODE_W-1:0] w_char_ext;
    logic [CODE_W-1:0] w_code_next;
    logic [CODE_W-1:0] w_mixed;
    logic [CODE_W-1:0] w_trial;
    logic [CODE_W-1:0] w_tsize_ext;
    logic [SLOT_W-1:0] n_rem;

    assign w_char_ext  = {{(CODE_W-CHAR_W){i_char[CHAR_W-1]}}, i_char};
    assign w_code_next = r_code * r_mult + w_char_ext;
    assign w_mixed     = {1'b0, r_factor} * r_code + {1'b0, r_shift};

    // restoring remainder step: bring in the next dividend bit, subtract if it fits
    assign w_trial     = {r_rem, r_dvd[CODE_W-1]};
    assign w_tsize_ext = {1'b0, r_tsize};

    always_comb begin
        if (w_trial >= w_tsize_ext) begin
            n_rem = SLOT_W'(w_trial - w_tsize_ext);
        end else begin
            n_rem = w_trial[SLOT_W-1:0];
        end
    end

    assign o_sts.char_zero = (i_char == '0);
    assign o_sts.out_free  = !r_out_valid || i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_slot          = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mult      <= MULT_RESET;
            r_factor    <= FACTOR_RESET;
            r_shift     <= SHIFT_RESET;
            r_tsize     <= TSIZE_RESET;
            r_code      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_MULT:   r_mult   <= i_cfg_data;
                    CFG_FACTOR: r_factor <= i_cfg_data[SLOT_W-1:0];
                    CFG_SHIFT:  r_shift  <= i_cfg_data[SLOT_W-1:0];
                    CFG_TSIZE:  r_tsize  <= i_cfg_data[SLOT_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.code_step) begin
                r_code <= w_code_next;
            end else if (i_cmd.mad_load) begin
                r_code <= '0;
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mad_load) begin
            r_dvd <= w_mixed;
            r_rem <= '0;
        end else if (i_cmd.div_step) begin
            r_dvd <= {r_dvd[CODE_W-2:0], 1'b0};
            r_rem <= n_rem;
        end
        if (i_cmd.out_load) begin
            // no modulus for a zero table size: drop to slot zero
            r_out <= (r_tsize == '0) ? '0 : r_rem;
        end
    end

endmodule

### design/string_hash_mad_slot_unit.sv
// Polynomial string hash with MAD compression.
// Input stream: one character per word in s_axis_tdata[7:0]. A non-zero
// character folds into the running code (code * multiplier + sign-extended
// character); s_axis_tready stays high for it.
// A zero character ends the string: the block forms factor * code + shift,
// clears the code, and reduces the sum modulo table_size with a one-bit-per-
// cycle remainder unit. s_axis_tready is low after a zero character while
// the unit runs its 32 remainder steps and until the slot is handed to the
// output register. The slot appears on m_axis_tdata[30:0].
// The output register lets the next string stream in while a slot waits;
// if the receiver still holds m_axis_tready low when the next slot is
// done, the remainder unit holds and input stays stalled.
// Configuration: i_cfg_index selects multiplier, factor, shift or table
// size; o_cfg_ready is always high. Write only while the block is idle.
// Synchronous active-low reset clears the code, empties the output and
// loads multiplier 33, factor 1, shift 0, table size 101.
module string_hash_mad_slot_unit
    import shms_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [7:0]        s_axis_tdata,   // [7:0] character
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [31:0]       m_axis_tdata,   // [30:0] slot, [31] zero
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_W-1:0]  i_cfg_data
);

    t_cmd              w_cmd;
    t_sts              w_sts;
    logic [SLOT_W-1:0] w_slot;

    assign o_cfg_ready  = 1'b1;
    assign m_axis_tdata = {1'b0, w_slot};

    shms_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    shms_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_char      (s_axis_tdata),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_slot      (w_slot)
    );

endmodule
